/* rtl/lom_pkg.sv */
// Shared types and constants for the limit order matching block.
// No dependencies; imported by the front end, the engine and the top level.
package lom_pkg;

  localparam int unsigned DEF_ORDER_SLOTS   = 32;
  localparam int unsigned DEF_PRICE_BITS    = 16;
  localparam int unsigned DEF_QUANTITY_BITS = 32;
  localparam int unsigned NUM_BITS          = 32;

  // result word kinds
  typedef enum logic [1:0] {
    KIND_FILL     = 2'd0,
    KIND_RESTED   = 2'd1,
    KIND_EMPTY    = 2'd2,
    KIND_REJECTED = 2'd3
  } kind_e;

  // engine sequencer
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_DECIDE
  } eng_state_e;

endpackage

/* rtl/limit_order_matching.sv */
// Limit order matching, price-time priority. An idle engine pops an order,
// scans every slot, drains the read port and then decides; an order of zero
// quantity goes from the pop straight to the decide step. Each fill that
// leaves quantity over is followed by a fresh scan of every slot; one that
// uses it up is followed directly by the status word unless the result
// output stalls. One order at a time in the engine, a two-word queue in
// front. Async active-low reset empties book and queue, next order number 1.
module limit_order_matching import lom_pkg::*; #(
  parameter int unsigned ORDER_SLOTS   = DEF_ORDER_SLOTS,
  parameter int unsigned PRICE_BITS    = DEF_PRICE_BITS,
  parameter int unsigned QUANTITY_BITS = DEF_QUANTITY_BITS
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic                     is_bid_i,
  input  logic [PRICE_BITS-1:0]    limit_price_i,
  input  logic [QUANTITY_BITS-1:0] order_quantity_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [1:0]               kind_o,
  output logic [PRICE_BITS-1:0]    trade_price_o,
  output logic [QUANTITY_BITS-1:0] trade_quantity_o,
  output logic [NUM_BITS-1:0]      order_number_o,
  output logic                     aggressor_buy_o,
  output logic                     last_o
);

  logic                     ord_valid, ord_pop, ord_buy;
  logic [PRICE_BITS-1:0]    ord_limit;
  logic [QUANTITY_BITS-1:0] ord_qty;
  logic [NUM_BITS-1:0]      ord_num;

  // order intake and queue
  lom_front #(
    .PRICE_BITS   (PRICE_BITS),
    .QUANTITY_BITS(QUANTITY_BITS)
  ) u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .is_bid_i, .limit_price_i,
    .order_quantity_i,
    .ord_valid_o(ord_valid), .ord_pop_i(ord_pop), .ord_buy_o(ord_buy),
    .ord_limit_o(ord_limit), .ord_qty_o(ord_qty), .ord_num_o(ord_num)
  );

  // matching engine and book
  lom_engine #(
    .ORDER_SLOTS  (ORDER_SLOTS),
    .PRICE_BITS   (PRICE_BITS),
    .QUANTITY_BITS(QUANTITY_BITS)
  ) u_engine (
    .clk_i, .rst_ni,
    .ord_valid_i(ord_valid), .ord_pop_o(ord_pop), .ord_buy_i(ord_buy),
    .ord_limit_i(ord_limit), .ord_qty_i(ord_qty), .ord_num_i(ord_num),
    .out_valid_o, .out_stall_i, .kind_o, .trade_price_o, .trade_quantity_o,
    .order_number_o, .aggressor_buy_o, .last_o
  );

endmodule

/* rtl/lom_front.sv */
// Front end: accepts order words, stamps the order number and queues them.
// Depends on lom_pkg.
module lom_front import lom_pkg::*; #(
  parameter int unsigned PRICE_BITS    = DEF_PRICE_BITS,
  parameter int unsigned QUANTITY_BITS = DEF_QUANTITY_BITS
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic                     is_bid_i,
  input  logic [PRICE_BITS-1:0]    limit_price_i,
  input  logic [QUANTITY_BITS-1:0] order_quantity_i,
  output logic                     ord_valid_o,
  input  logic                     ord_pop_i,
  output logic                     ord_buy_o,
  output logic [PRICE_BITS-1:0]    ord_limit_o,
  output logic [QUANTITY_BITS-1:0] ord_qty_o,
  output logic [NUM_BITS-1:0]      ord_num_o
);

  logic                     q_buy_q   [2];
  logic [PRICE_BITS-1:0]    q_limit_q [2];
  logic [QUANTITY_BITS-1:0] q_qty_q   [2];
  logic [NUM_BITS-1:0]      q_num_q   [2];
  logic                     wr_ptr_q, rd_ptr_q;
  logic [1:0]               count_q, count_d;
  logic [NUM_BITS-1:0]      next_num_q;
  logic                     push, pop;

  assign in_stall_o  = (count_q == 2'd2);
  assign push        = in_valid_i && !in_stall_o;
  assign ord_valid_o = (count_q != 2'd0);
  assign pop         = ord_pop_i && ord_valid_o;

  assign ord_buy_o   = q_buy_q[rd_ptr_q];
  assign ord_limit_o = q_limit_q[rd_ptr_q];
  assign ord_qty_o   = q_qty_q[rd_ptr_q];
  assign ord_num_o   = q_num_q[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    if (push && !pop) count_d = count_q + 2'd1;
    else if (!push && pop) count_d = count_q - 2'd1;
  end

  // pointers, fill count and order numbering
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q   <= 1'b0;
      rd_ptr_q   <= 1'b0;
      count_q    <= 2'd0;
      next_num_q <= NUM_BITS'(1);
    end else begin
      count_q <= count_d;
      if (push) begin
        wr_ptr_q   <= ~wr_ptr_q;
        next_num_q <= next_num_q + NUM_BITS'(1);
      end
      if (pop) rd_ptr_q <= ~rd_ptr_q;
    end
  end

  // queue payload
  always_ff @(posedge clk_i) begin
    if (push) begin
      q_buy_q[wr_ptr_q]   <= is_bid_i;
      q_limit_q[wr_ptr_q] <= limit_price_i;
      q_qty_q[wr_ptr_q]   <= order_quantity_i;
      q_num_q[wr_ptr_q]   <= next_num_q;
    end
  end

endmodule

/* rtl/lom_engine.sv */
// Back end: scans the slot store for the best crossing order, emits fills
// and the status word, rests or rejects a remainder. Depends on lom_pkg.
module lom_engine import lom_pkg::*; #(
  parameter int unsigned ORDER_SLOTS   = DEF_ORDER_SLOTS,
  parameter int unsigned PRICE_BITS    = DEF_PRICE_BITS,
  parameter int unsigned QUANTITY_BITS = DEF_QUANTITY_BITS
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     ord_valid_i,
  output logic                     ord_pop_o,
  input  logic                     ord_buy_i,
  input  logic [PRICE_BITS-1:0]    ord_limit_i,
  input  logic [QUANTITY_BITS-1:0] ord_qty_i,
  input  logic [NUM_BITS-1:0]      ord_num_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [1:0]               kind_o,
  output logic [PRICE_BITS-1:0]    trade_price_o,
  output logic [QUANTITY_BITS-1:0] trade_quantity_o,
  output logic [NUM_BITS-1:0]      order_number_o,
  output logic                     aggressor_buy_o,
  output logic                     last_o
);

  localparam int unsigned IW = $clog2(ORDER_SLOTS);

  // slot store
  logic                     slot_vld_q [ORDER_SLOTS];
  logic                     mem_side   [ORDER_SLOTS];
  logic [PRICE_BITS-1:0]    mem_price  [ORDER_SLOTS];
  logic [QUANTITY_BITS-1:0] mem_qty    [ORDER_SLOTS];
  logic [NUM_BITS-1:0]      mem_num    [ORDER_SLOTS];

  logic                     rd_side_q;
  logic [PRICE_BITS-1:0]    rd_price_q;
  logic [QUANTITY_BITS-1:0] rd_qty_q;
  logic [NUM_BITS-1:0]      rd_num_q;
  logic [IW-1:0]            rd_idx_q;
  logic                     rd_vld_q, rd_vld_d;

  eng_state_e               state_q, state_d;
  logic [IW-1:0]            scan_idx_q, scan_idx_d;

  // current order
  logic                     buy_q, buy_d;
  logic [PRICE_BITS-1:0]    limit_q, limit_d;
  logic [QUANTITY_BITS-1:0] rem_q, rem_d;
  logic [NUM_BITS-1:0]      num_q, num_d;

  // best candidate so far
  logic                     found_q, found_d;
  logic [IW-1:0]            best_idx_q, best_idx_d;
  logic [PRICE_BITS-1:0]    best_price_q, best_price_d;
  logic [QUANTITY_BITS-1:0] best_qty_q, best_qty_d;
  logic [NUM_BITS-1:0]      best_age_q, best_age_d;
  logic                     free_found_q, free_found_d;
  logic [IW-1:0]            free_idx_q, free_idx_d;

  // output register
  logic                     out_valid_q, out_valid_d;
  kind_e                    kind_q, kind_d;
  logic [PRICE_BITS-1:0]    price_q, price_d;
  logic [QUANTITY_BITS-1:0] qty_q, qty_d;
  logic [NUM_BITS-1:0]      onum_q, onum_d;
  logic                     obuy_q, obuy_d;
  logic                     last_q, last_d;
  logic                     out_free;

  // store writes
  logic                     we_qty, we_all, clr_vld;
  logic [IW-1:0]            wr_idx;
  logic [QUANTITY_BITS-1:0] wr_qty;

  logic [NUM_BITS-1:0]      age;
  logic                     crosses, better;
  logic [QUANTITY_BITS-1:0] match;

  assign out_free = !out_valid_q || !out_stall_i;
  assign match    = (best_qty_q < rem_q) ? best_qty_q : rem_q;

  // candidate test on the registered read word
  always_comb begin
    age     = (num_q + NUM_BITS'(1)) - rd_num_q;
    crosses = buy_q ? (rd_price_q <= limit_q) : (rd_price_q >= limit_q);
    better  = buy_q ? (rd_price_q < best_price_q) : (rd_price_q > best_price_q);
    better  = better || ((rd_price_q == best_price_q) && (age > best_age_q));
  end

  // sequencer
  always_comb begin
    state_d      = state_q;
    scan_idx_d   = scan_idx_q;
    buy_d        = buy_q;
    limit_d      = limit_q;
    rem_d        = rem_q;
    num_d        = num_q;
    found_d      = found_q;
    best_idx_d   = best_idx_q;
    best_price_d = best_price_q;
    best_qty_d   = best_qty_q;
    best_age_d   = best_age_q;
    free_found_d = free_found_q;
    free_idx_d   = free_idx_q;
    out_valid_d  = out_valid_q && out_stall_i;
    kind_d       = kind_q;
    price_d      = price_q;
    qty_d        = qty_q;
    onum_d       = onum_q;
    obuy_d       = obuy_q;
    last_d       = last_q;
    ord_pop_o    = 1'b0;
    rd_vld_d     = 1'b0;
    we_qty       = 1'b0;
    we_all       = 1'b0;
    clr_vld      = 1'b0;
    wr_idx       = best_idx_q;
    wr_qty       = best_qty_q - match;

    // fold in the word read last cycle
    if (rd_vld_q) begin
      if (slot_vld_q[rd_idx_q]) begin
        if ((rd_side_q != buy_q) && crosses && (!found_q || better)) begin
          found_d      = 1'b1;
          best_idx_d   = rd_idx_q;
          best_price_d = rd_price_q;
          best_qty_d   = rd_qty_q;
          best_age_d   = age;
        end
      end else if (!free_found_q) begin
        free_found_d = 1'b1;
        free_idx_d   = rd_idx_q;
      end
    end

    case (state_q)
      ST_IDLE: begin
        if (ord_valid_i) begin
          ord_pop_o    = 1'b1;
          buy_d        = ord_buy_i;
          limit_d      = ord_limit_i;
          rem_d        = ord_qty_i;
          num_d        = ord_num_i;
          found_d      = 1'b0;
          free_found_d = 1'b0;
          scan_idx_d   = '0;
          state_d      = (ord_qty_i == '0) ? ST_DECIDE : ST_SCAN;
        end
      end
      ST_SCAN: begin
        rd_vld_d   = 1'b1;
        scan_idx_d = scan_idx_q + IW'(1);
        if (scan_idx_q == IW'(ORDER_SLOTS - 1)) state_d = ST_DRAIN;
      end
      ST_DRAIN: begin
        state_d = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          onum_d      = num_q;
          obuy_d      = buy_q;
          if (rem_q == '0) begin
            kind_d  = KIND_EMPTY;
            price_d = limit_q;
            qty_d   = '0;
            last_d  = 1'b1;
            state_d = ST_IDLE;
          end else if (found_q) begin
            // one fill against the best resting order
            kind_d       = KIND_FILL;
            price_d      = best_price_q;
            qty_d        = match;
            last_d       = 1'b0;
            we_qty       = 1'b1;
            clr_vld      = (wr_qty == '0);
            rem_d        = rem_q - match;
            found_d      = 1'b0;
            free_found_d = 1'b0;
            scan_idx_d   = '0;
            state_d      = (rem_q == match) ? ST_DECIDE : ST_SCAN;
          end else if (free_found_q) begin
            kind_d  = KIND_RESTED;
            price_d = limit_q;
            qty_d   = rem_q;
            last_d  = 1'b1;
            we_all  = 1'b1;
            wr_idx  = free_idx_q;
            state_d = ST_IDLE;
          end else begin
            kind_d  = KIND_REJECTED;
            price_d = limit_q;
            qty_d   = rem_q;
            last_d  = 1'b1;
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      out_valid_q  <= 1'b0;
      rd_vld_q     <= 1'b0;
      found_q      <= 1'b0;
      free_found_q <= 1'b0;
      scan_idx_q   <= '0;
      for (int i = 0; i < ORDER_SLOTS; i++) slot_vld_q[i] <= 1'b0;
    end else begin
      state_q      <= state_d;
      out_valid_q  <= out_valid_d;
      rd_vld_q     <= rd_vld_d;
      found_q      <= found_d;
      free_found_q <= free_found_d;
      scan_idx_q   <= scan_idx_d;
      if (clr_vld) slot_vld_q[wr_idx] <= 1'b0;
      if (we_all)  slot_vld_q[wr_idx] <= 1'b1;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    buy_q        <= buy_d;
    limit_q      <= limit_d;
    rem_q        <= rem_d;
    num_q        <= num_d;
    best_idx_q   <= best_idx_d;
    best_price_q <= best_price_d;
    best_qty_q   <= best_qty_d;
    best_age_q   <= best_age_d;
    free_idx_q   <= free_idx_d;
    kind_q       <= kind_d;
    price_q      <= price_d;
    qty_q        <= qty_d;
    onum_q       <= onum_d;
    obuy_q       <= obuy_d;
    last_q       <= last_d;
    rd_idx_q     <= scan_idx_q;
  end

  // slot store: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_all) begin
      mem_side[wr_idx]  <= buy_q;
      mem_price[wr_idx] <= limit_q;
      mem_qty[wr_idx]   <= rem_q;
      mem_num[wr_idx]   <= num_q;
    end else if (we_qty) begin
      mem_qty[wr_idx]   <= wr_qty;
    end
    rd_side_q  <= mem_side[scan_idx_q];
    rd_price_q <= mem_price[scan_idx_q];
    rd_qty_q   <= mem_qty[scan_idx_q];
    rd_num_q   <= mem_num[scan_idx_q];
  end

  assign out_valid_o      = out_valid_q;
  assign kind_o           = kind_q;
  assign trade_price_o    = price_q;
  assign trade_quantity_o = qty_q;
  assign order_number_o   = onum_q;
  assign aggressor_buy_o  = obuy_q;
  assign last_o           = last_q;

endmodule

/* rtl/lom_checker.sv */
// Port-level checks on the matching block's result words.
// Depends on lom_pkg; bound to limit_order_matching below.
module lom_checker import lom_pkg::*; #(
  parameter int unsigned PRICE_BITS    = DEF_PRICE_BITS,
  parameter int unsigned QUANTITY_BITS = DEF_QUANTITY_BITS
) (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     out_valid_o,
  input logic                     out_stall_i,
  input logic [1:0]               kind_o,
  input logic [PRICE_BITS-1:0]    trade_price_o,
  input logic [QUANTITY_BITS-1:0] trade_quantity_o,
  input logic [NUM_BITS-1:0]      order_number_o,
  input logic                     last_o
);

  // stalled word holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(trade_quantity_o)
      && $stable(kind_o) && $stable(trade_price_o))
    else $error("stalled result word changed");

  // only the status word closes an order
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (last_o == (kind_o != KIND_FILL)))
    else $error("last flag disagrees with kind");

  // fills always trade something, empty status carries nothing
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o == KIND_FILL || kind_o == KIND_EMPTY) |->
      ((trade_quantity_o != '0) == (kind_o == KIND_FILL)))
    else $error("bad quantity on result word");

  // fills of one order share its number
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !last_o ##1 out_valid_o |->
      order_number_o == $past(order_number_o))
    else $error("order number changed within an order");

endmodule

bind limit_order_matching lom_checker #(
  .PRICE_BITS   (PRICE_BITS),
  .QUANTITY_BITS(QUANTITY_BITS)
) u_lom_checker (
  .clk_i, .rst_ni, .out_valid_o, .out_stall_i, .kind_o, .trade_price_o,
  .trade_quantity_o, .order_number_o, .last_o
);
